>>> rtl/u8bmp_pkg.sv
// Package for the UTF-8 to BMP stream decoder: widths, constants, lead-byte
// classes and the result record passed from the decode core to the top level.
// No dependencies.
`default_nettype none

package u8bmp_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 16;
    localparam int PEND_W = 2;

    localparam logic [CP_W-1:0]   REPLACEMENT_CP = 16'hFFFD;
    localparam logic [BYTE_W-1:0] CONT_MASK      = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG       = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_PAYLOAD  = 8'hFF >> 3;
    localparam logic [BYTE_W-1:0] LEAD3_PAYLOAD  = 8'hFF >> 4;
    localparam logic [BYTE_W-1:0] CONT_PAYLOAD   = 8'hFF >> 2;

    // Pending counts loaded by each lead class
    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_LEAD2 = 2'd1;
    localparam logic [PEND_W-1:0] PEND_LEAD3 = 2'd2;
    localparam logic [PEND_W-1:0] PEND_LEAD4 = 2'd3;

    // Class of a byte seen while no sequence is open
    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_BAD,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4
    } t_lead_cls;

    // One decoded beat from core to output stage
    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] codepoint;
    } t_result;

    // Count of leading ones, folded into the classes that matter
    function automatic t_lead_cls classify_lead(input logic [BYTE_W-1:0] b);
        t_lead_cls cls;
        cls = CLS_BAD;
        casez (b)
            8'b0???????: cls = CLS_ASCII;
            8'b110?????: cls = CLS_LEAD2;
            8'b1110????: cls = CLS_LEAD3;
            8'b11110???: cls = CLS_LEAD4;
            default:     cls = CLS_BAD;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

>>> rtl/u8bmp_ifs.sv
// Valid/ready stream interfaces for the decoder: raw byte input and
// codepoint output. Depends on u8bmp_pkg.
`default_nettype none

interface u8bmp_byte_if
    import u8bmp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8bmp_cp_if
    import u8bmp_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] codepoint;

    modport source (output valid, output codepoint, input ready);
    modport sink   (input valid, input codepoint, output ready);
endinterface

`default_nettype wire

>>> rtl/u8bmp_core.sv
// Decode core: sequence state registers and the per-byte next-state and
// result logic. Depends on u8bmp_pkg.
`default_nettype none

module u8bmp_core
    import u8bmp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_result                o_result
);

    logic [PEND_W-1:0] r_pending, n_pending;
    logic [CP_W-1:0]   r_partial, n_partial;
    logic              r_skip, n_skip;

    t_lead_cls         lead_cls;
    logic [CP_W-1:0]   cont_bits;
    logic [CP_W-1:0]   merged;
    logic [PEND_W-1:0] pend_dec;
    logic              is_cont;

    assign lead_cls  = classify_lead(i_byte);
    assign is_cont   = (i_byte & CONT_MASK) == CONT_TAG;
    assign pend_dec  = r_pending - PEND_W'(1);
    // two bytes still awaited: payload sits above the last byte's six bits
    assign cont_bits = pend_dec[0] ? {2'b0, i_byte & CONT_PAYLOAD, 6'b0}
                                   : {8'b0, i_byte & CONT_PAYLOAD};
    assign merged    = r_partial | cont_bits;

    // Next state and result for the byte in the input stage
    always_comb begin
        n_pending          = r_pending;
        n_partial          = r_partial;
        n_skip             = r_skip;
        o_result.valid     = 1'b0;
        o_result.codepoint = REPLACEMENT_CP;
        if (r_pending == PEND_NONE) begin
            unique case (lead_cls)
                CLS_ASCII: begin
                    o_result.valid     = 1'b1;
                    o_result.codepoint = {8'b0, i_byte};
                end
                CLS_LEAD2: begin
                    n_partial = {5'b0, i_byte & LEAD2_PAYLOAD, 3'b0} << 3;
                    n_pending = PEND_LEAD2;
                    n_skip    = 1'b0;
                end
                CLS_LEAD3: begin
                    n_partial = {i_byte[3:0] & LEAD3_PAYLOAD[3:0], 12'b0};
                    n_pending = PEND_LEAD3;
                    n_skip    = 1'b0;
                end
                CLS_LEAD4: begin
                    n_partial = '0;
                    n_pending = PEND_LEAD4;
                    n_skip    = 1'b1;
                end
                default: begin
                    o_result.valid = 1'b1;
                end
            endcase
        end else if (r_skip) begin
            // four-byte form: drop trailing bytes, replace at the last one
            n_pending = pend_dec;
            if (pend_dec == PEND_NONE) begin
                n_skip         = 1'b0;
                o_result.valid = 1'b1;
            end
        end else if (!is_cont) begin
            n_pending      = PEND_NONE;
            n_partial      = '0;
            o_result.valid = 1'b1;
        end else begin
            n_pending = pend_dec;
            if (pend_dec == PEND_NONE) begin
                n_partial          = '0;
                o_result.valid     = 1'b1;
                o_result.codepoint = merged;
            end else begin
                n_partial = merged;
            end
        end
    end

    // State update, one byte per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= PEND_NONE;
            r_partial <= '0;
            r_skip    <= 1'b0;
        end else if (i_step) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_skip    <= n_skip;
        end
    end

endmodule

`default_nettype wire

>>> rtl/utf8_bmp_stream_decoder_top.sv
// Top level of the UTF-8 to BMP stream decoder: input byte register, decode
// core and output codepoint register. Depends on u8bmp_pkg, u8bmp_ifs, u8bmp_core.
//
// Usage:
//   i_in  : byte stream, one UTF-8 byte per beat (valid/ready).
//   o_out : codepoint stream, one 16-bit BMP codepoint per beat (valid/ready).
//   Each byte gives zero or one codepoint. Malformed sequences and four-byte
//   forms give U+FFFD; a sequence cut short is held until more bytes arrive.
// Timing:
//   A byte taken into the input register is decoded by the core, and its
//   codepoint is captured in the output register, from which o_out takes it.
//   Throughput is one byte per cycle while o_out is not stalled, set by the
//   single decode stage between the input register and the output register.
// Reset:
//   Synchronous, active low; clears the sequence state and both stage valids.
// Stall:
//   While o_out is stalled with a codepoint waiting, one more byte is held in
//   the input register; i_in.ready drops only when both stages are full.
`default_nettype none

module utf8_bmp_stream_decoder_top
    import u8bmp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u8bmp_byte_if.sink  i_in,
    u8bmp_cp_if.source  o_out
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;

    logic              out_free;
    logic              step;
    logic              in_fire;
    t_result           result;

    assign out_free   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || step;
    assign in_fire    = i_in.valid && i_in.ready;

    u8bmp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    // Output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && result.valid) begin
            r_out_cp <= result.codepoint;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.codepoint = r_out_cp;

endmodule

`default_nettype wire

>>> verif/utf8_bmp_stream_decoder_top_tb.sv
// Self-checking testbench for utf8_bmp_stream_decoder_top: directed byte runs, then a
// random stream, with each codepoint beat checked against a behavioral decoder.
// Depends on u8bmp_pkg, u8bmp_ifs and the decoder RTL.
`default_nettype none

module utf8_bmp_stream_decoder_top_tb;
    import u8bmp_pkg::*;

    localparam int IDLE_PCT    = 28;
    localparam int STALL_LIMIT = 1000;
    localparam int RAND_ITEMS  = 1000;
    localparam int TAIL_CYCLES = 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Testbench-side drivers, known from time zero
    logic              src_valid  = 1'b0;
    logic [BYTE_W-1:0] src_byte   = '0;
    logic              sink_ready = 1'b0;

    // Throttle off while set: both sides run without idle cycles
    bit quiet = 1'b0;

    int err_cnt = 0;
    int stall_cycles;

    // Behavioral decoder state
    logic [PEND_W-1:0] dec_pend = PEND_NONE;
    logic [CP_W-1:0]   dec_acc  = '0;
    logic              dec_skip = 1'b0;
    logic [CP_W-1:0]   decoded_cps[$];
    logic [CP_W-1:0]   want_cp;

    u8bmp_byte_if byte_bus();
    u8bmp_cp_if   cp_bus();

    assign byte_bus.valid   = src_valid;
    assign byte_bus.in_byte = src_byte;
    assign cp_bus.ready     = sink_ready;

    utf8_bmp_stream_decoder_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_bus),
        .o_out   (cp_bus)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Lead class from the count of leading ones
    function automatic t_lead_cls lead_class(input logic [BYTE_W-1:0] b);
        int ones;
        ones = 0;
        while (ones < BYTE_W && b[BYTE_W-1-ones]) ones++;
        case (ones)
            0:       return CLS_ASCII;
            2:       return CLS_LEAD2;
            3:       return CLS_LEAD3;
            4:       return CLS_LEAD4;
            default: return CLS_BAD;
        endcase
    endfunction

    // Advance the decoder by one byte; queue the codepoint it yields, if any
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        logic [CP_W-1:0] wide;
        if (dec_pend == PEND_NONE) begin
            case (lead_class(b))
                CLS_ASCII: begin
                    decoded_cps.push_back({8'h00, b});
                end
                CLS_LEAD2: begin
                    wide     = {8'h00, b & LEAD2_PAYLOAD};
                    dec_acc  = wide << 6;
                    dec_pend = PEND_LEAD2;
                    dec_skip = 1'b0;
                end
                CLS_LEAD3: begin
                    wide     = {8'h00, b & LEAD3_PAYLOAD};
                    dec_acc  = wide << 12;
                    dec_pend = PEND_LEAD3;
                    dec_skip = 1'b0;
                end
                CLS_LEAD4: begin
                    dec_acc  = '0;
                    dec_pend = PEND_LEAD4;
                    dec_skip = 1'b1;
                end
                default: begin
                    decoded_cps.push_back(REPLACEMENT_CP);
                end
            endcase
        end else if (dec_skip) begin
            // four-byte form: trailing bytes taken unchecked
            dec_pend = dec_pend - 1'b1;
            if (dec_pend == PEND_NONE) begin
                dec_skip = 1'b0;
                decoded_cps.push_back(REPLACEMENT_CP);
            end
        end else if ((b & CONT_MASK) != CONT_TAG) begin
            // bad continuation is consumed, not re-read as a lead
            dec_pend = PEND_NONE;
            dec_acc  = '0;
            decoded_cps.push_back(REPLACEMENT_CP);
        end else begin
            wide = {8'h00, b & CONT_PAYLOAD};
            if (dec_pend == PEND_LEAD3) dec_acc = dec_acc | (wide << 6);
            else                        dec_acc = dec_acc | wide;
            dec_pend = dec_pend - 1'b1;
            if (dec_pend == PEND_NONE) begin
                decoded_cps.push_back(dec_acc);
                dec_acc = '0;
            end
        end
    endfunction

    // One byte beat, with an optional random gap before it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            src_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_byte  <= b;
        @(posedge clk);
        while (!byte_bus.ready) @(posedge clk);
        decode_byte(b);
    endtask

    // Stop sending, wait for all codepoints, then idle for the extra cycles asked
    task automatic settle(input int extra);
        src_valid <= 1'b0;
        @(posedge clk);
        while (decoded_cps.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] cont_byte();
        logic [31:0] r;
        r = $urandom;
        return {2'b10, r[5:0]};
    endfunction

    task automatic test_ascii_edges();
        send_byte(8'h00);
        send_byte(8'h7F);
    endtask

    // Stray continuation and leads with one or five+ ones
    task automatic test_lone_bad_leads();
        send_byte(8'h80);
        send_byte(8'hF8);
        send_byte(8'hFF);
    endtask

    task automatic test_two_byte();
        send_byte(8'hDF);
        send_byte(8'hBF);
        // overlong NUL, decoded as its bits say
        send_byte(8'hC0);
        send_byte(8'h80);
    endtask

    task automatic test_three_byte();
        send_byte(8'hEF);
        send_byte(8'hBF);
        send_byte(8'hBF);
        // surrogate half passes unchecked
        send_byte(8'hED);
        send_byte(8'hA0);
        send_byte(8'h80);
    endtask

    task automatic test_four_byte();
        send_byte(8'hF0);
        send_byte(8'h9F);
        send_byte(8'h98);
        send_byte(8'h80);
    endtask

    task automatic test_bad_continuation();
        send_byte(8'hC3);
        send_byte(8'h41);
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'h28);
    endtask

    // Sequence cut short: lead held across a full drain
    task automatic test_held_sequence();
        send_byte(8'hC3);
        settle(TAIL_CYCLES);
        send_byte(8'hA9);
    endtask

    // Mostly well-formed sequences with random payload, plus noise and breaks
    task automatic test_random_stream();
        int sent;
        int pick;
        logic [31:0] r;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            quiet = (sent >= 400 && sent < 600);
            pick  = $urandom_range(99);
            r     = $urandom;
            if (pick < 20) begin
                send_byte({1'b0, r[6:0]});
                sent += 1;
            end else if (pick < 40) begin
                send_byte({3'b110, r[4:0]});
                send_byte(cont_byte());
                sent += 2;
            end else if (pick < 58) begin
                send_byte({4'b1110, r[3:0]});
                send_byte(cont_byte());
                send_byte(cont_byte());
                sent += 3;
            end else if (pick < 70) begin
                send_byte({5'b11110, r[2:0]});
                send_byte(8'($urandom));
                send_byte(8'($urandom));
                send_byte(8'($urandom));
                sent += 4;
            end else if (pick < 85) begin
                send_byte(r[15:8]);
                sent += 1;
            end else begin
                // broken sequence: lead, maybe one good continuation, then any byte
                if (r[16]) begin
                    send_byte({3'b110, r[4:0]});
                end else begin
                    send_byte({4'b1110, r[3:0]});
                    if (r[17]) send_byte(cont_byte());
                end
                send_byte(8'($urandom));
                sent += 2;
            end
        end
        quiet = 1'b0;
    endtask

    // Sink side: check each codepoint beat, then pick next ready
    always @(posedge clk) begin
        if (!rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (cp_bus.valid && cp_bus.ready) begin
                if (decoded_cps.size() == 0) begin
                    report_mismatch($sformatf("unexpected codepoint %h", cp_bus.codepoint));
                end else begin
                    want_cp = decoded_cps.pop_front();
                    if (cp_bus.codepoint !== want_cp)
                        report_mismatch($sformatf("codepoint got %h want %h",
                                                  cp_bus.codepoint, want_cp));
                end
            end
            sink_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: too many cycles without any beat on either side
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((byte_bus.valid && byte_bus.ready) || (cp_bus.valid && cp_bus.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ascii_edges();
        test_lone_bad_leads();
        test_two_byte();
        test_three_byte();
        test_four_byte();
        test_bad_continuation();
        test_held_sequence();
        test_random_stream();

        settle(TAIL_CYCLES);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
